>>> design/mtdm_pkg.sv
// Shared types and constants for the motor telemetry derived-metrics block.
package mtdm_pkg;

    localparam int MD_W = 64;
    localparam int MD_CNT_W = $clog2(MD_W);

    typedef enum logic
    {
        MD_MUL,
        MD_DIV
    } md_op_t;

    typedef struct packed
    {
        logic   start;
        md_op_t op;
    } md_req_t;

    typedef struct packed
    {
        logic busy;
        logic done;
    } md_rsp_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_POLE_PAIRS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_CIRC   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BATT_EMPTY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BATT_FULL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BATT_CAP     = 3'd4;

    localparam logic [7:0]  POLE_PAIRS_RST = 8'd15;
    localparam logic [11:0] WHEEL_CIRC_RST = 12'd890;
    localparam logic [14:0] BATT_EMPTY_RST = 15'd480;
    localparam logic [14:0] BATT_FULL_RST  = 15'd672;
    localparam logic [15:0] BATT_CAP_RST   = 16'd960;

    localparam int SMOOTH_DIV = 5;

endpackage

>>> design/motor_telemetry_derived_metrics_top.sv
// Top level: sequencer, state and output register for the derived-metrics block.
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------------
//  input    | in_valid / in_stall    | voltage_dv .. tachometer_abs
//  output   | out_valid / out_stall  | watts_mw .. range_estimate_m
//  config   | cfg_we                 | cfg_index, cfg_data
//
// Each item runs 10 to 15 operations through one shared multiply/divide unit.
// in_stall stays high from acceptance until the result is loaded into the
// output register; the next item is taken while that result waits.
// A stalled output holds the sequencer at its last step.
// Reset loads the default configuration and clears power, peak and session state.
module motor_telemetry_derived_metrics_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mtdm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mtdm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [15:0]                  voltage_dv,
    input  logic signed [19:0]                  motor_current_ca,
    input  logic signed [20:0]                  electrical_rpm,
    input  logic signed [31:0]                  tachometer,
    input  logic [30:0]                         tachometer_abs,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [34:0]                  watts_mw,
    output logic signed [34:0]                  avg_watts_mw,
    output logic [33:0]                         peak_watts_mw,
    output logic [13:0]                         battery_percent_centi,
    output logic signed [28:0]                  speed_milli_kmh,
    output logic signed [41:0]                  session_distance_m,
    output logic [33:0]                         total_distance_m,
    output logic signed [41:0]                  range_estimate_m
);

    localparam int W = mtdm_pkg::MD_W;

    localparam logic signed [W-1:0] S35_MAX = (64'sd1 <<< 34) - 64'sd1;
    localparam logic signed [W-1:0] S35_MIN = -(64'sd1 <<< 34);
    localparam logic signed [W-1:0] S29_MAX = (64'sd1 <<< 28) - 64'sd1;
    localparam logic signed [W-1:0] S29_MIN = -(64'sd1 <<< 28);
    localparam logic signed [W-1:0] S42_MAX = (64'sd1 <<< 41) - 64'sd1;
    localparam logic signed [W-1:0] S42_MIN = -(64'sd1 <<< 41);
    localparam logic signed [W-1:0] S48_MAX = (64'sd1 <<< 47) - 64'sd1;
    localparam logic signed [W-1:0] S48_MIN = -(64'sd1 <<< 47);
    localparam logic signed [W-1:0] U34_MAX = (64'sd1 <<< 34) - 64'sd1;
    localparam logic signed [W-1:0] PCT_MAX = 64'sd10000;

    typedef enum logic [4:0]
    {
        S_IDLE,
        S_PWR,
        S_AVG,
        S_PCT_M,
        S_PCT_D,
        S_DEN,
        S_CS,
        S_SPD_M,
        S_SPD_D,
        S_SES_M,
        S_SES_D,
        S_TOT_M,
        S_TOT_D,
        S_RNG_M1,
        S_RNG_M2,
        S_RNG_D,
        S_OUT
    } state_t;

    function automatic logic signed [W-1:0] sat_s(input logic signed [W-1:0] v,
                                                  input logic signed [W-1:0] lo,
                                                  input logic signed [W-1:0] hi);
        logic signed [W-1:0] r;
        r = v;
        if (v < lo)
        begin
            r = lo;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

    state_t state_reg;
    logic   go_reg;
    logic   out_valid_reg;

    logic [7:0]  pole_pairs_reg;
    logic [11:0] circ_reg;
    logic [14:0] empty_reg;
    logic [14:0] full_reg;
    logic [15:0] cap_reg;

    logic signed [15:0] v_reg;
    logic signed [19:0] cur_reg;
    logic signed [20:0] rpm_reg;
    logic signed [31:0] tach_reg;
    logic [30:0]        tabs_reg;

    logic signed [34:0] watts_reg;
    logic signed [35:0] avg_reg;
    logic [33:0]        peak_reg;
    logic signed [31:0] prev_reg;
    logic signed [47:0] sum_reg;
    logic [13:0]        pct_reg;
    logic [17:0]        den_reg;
    logic signed [W-1:0] tmp_reg;
    logic signed [28:0] speed_reg;
    logic signed [41:0] sess_reg;
    logic [33:0]        total_reg;
    logic signed [41:0] range_reg;

    logic signed [34:0] o_watts_reg;
    logic signed [34:0] o_avg_reg;
    logic [33:0]        o_peak_reg;
    logic [13:0]        o_pct_reg;
    logic signed [28:0] o_speed_reg;
    logic signed [41:0] o_sess_reg;
    logic [33:0]        o_total_reg;
    logic signed [41:0] o_range_reg;

    mtdm_pkg::md_req_t   md_req;
    mtdm_pkg::md_rsp_t   md_rsp;
    logic signed [W-1:0] md_a;
    logic signed [W-1:0] md_b;
    logic signed [W-1:0] md_res;

    logic                is_op;
    logic signed [15:0]  span;
    logic [7:0]          pp_eff;
    logic signed [W-1:0] watts_sat;
    logic signed [W-1:0] avg_sum;
    logic signed [W-1:0] avg_x10;
    logic signed [W-1:0] sum_step;
    logic signed [W-1:0] sum_sat;
    logic signed [W-1:0] pct_clamp;

    always_comb
    begin
        is_op     = (state_reg != S_IDLE) && (state_reg != S_OUT);
        span      = $signed({1'b0, full_reg}) - $signed({1'b0, empty_reg});
        pp_eff    = (pole_pairs_reg == '0) ? 8'd1 : pole_pairs_reg;
        watts_sat = sat_s(md_res, S35_MIN, S35_MAX);
        avg_sum   = W'(avg_reg) + md_res;
        avg_x10   = (W'(avg_reg) <<< 3) + (W'(avg_reg) <<< 1);
        sum_step  = W'(sum_reg) + W'(tach_reg) - W'(prev_reg);
        sum_sat   = sat_s(sum_step, S48_MIN, S48_MAX);
        pct_clamp = sat_s(md_res, '0, PCT_MAX);
    end

    always_comb
    begin
        md_req.start = is_op && !go_reg;
        md_req.op    = mtdm_pkg::MD_MUL;
        md_a         = '0;
        md_b         = '0;
        case (state_reg)
            S_PWR:
            begin
                md_a = W'(v_reg);
                md_b = W'(cur_reg);
            end
            S_AVG:
            begin
                md_req.op = mtdm_pkg::MD_DIV;
                md_a      = W'(watts_reg) - W'(avg_reg);
                md_b      = W'(mtdm_pkg::SMOOTH_DIV);
            end
            S_PCT_M:
            begin
                md_a = W'(v_reg) - W'($signed({1'b0, empty_reg}));
                md_b = PCT_MAX;
            end
            S_PCT_D:
            begin
                md_req.op = mtdm_pkg::MD_DIV;
                md_a      = tmp_reg;
                md_b      = W'(span);
            end
            S_DEN:
            begin
                md_a = W'(pp_eff);
                md_b = 64'sd1000;
            end
            S_CS:
            begin
                md_a = W'(circ_reg);
                md_b = 64'sd60;
            end
            S_SPD_M:
            begin
                md_a = W'(rpm_reg);
                md_b = tmp_reg;
            end
            S_SPD_D, S_SES_D, S_TOT_D:
            begin
                md_req.op = mtdm_pkg::MD_DIV;
                md_a      = tmp_reg;
                md_b      = W'(den_reg);
            end
            S_SES_M:
            begin
                md_a = W'(sum_reg);
                md_b = W'(circ_reg);
            end
            S_TOT_M:
            begin
                md_a = W'(tabs_reg);
                md_b = W'(circ_reg);
            end
            S_RNG_M1:
            begin
                md_a = W'(cap_reg);
                md_b = W'(pct_reg);
            end
            S_RNG_M2:
            begin
                md_a = tmp_reg;
                md_b = W'(speed_reg);
            end
            S_RNG_D:
            begin
                md_req.op = mtdm_pkg::MD_DIV;
                md_a      = tmp_reg;
                md_b      = avg_x10;
            end
            default:
            begin
                md_a = '0;
            end
        endcase
    end

    mtdm_muldiv u_muldiv
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (md_req),
        .a      (md_a),
        .b      (md_b),
        .rsp    (md_rsp),
        .result (md_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pole_pairs_reg <= mtdm_pkg::POLE_PAIRS_RST;
            circ_reg       <= mtdm_pkg::WHEEL_CIRC_RST;
            empty_reg      <= mtdm_pkg::BATT_EMPTY_RST;
            full_reg       <= mtdm_pkg::BATT_FULL_RST;
            cap_reg        <= mtdm_pkg::BATT_CAP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mtdm_pkg::CFG_POLE_PAIRS: pole_pairs_reg <= cfg_data[7:0];
                mtdm_pkg::CFG_WHEEL_CIRC: circ_reg       <= cfg_data[11:0];
                mtdm_pkg::CFG_BATT_EMPTY: empty_reg      <= cfg_data[14:0];
                mtdm_pkg::CFG_BATT_FULL:  full_reg       <= cfg_data[14:0];
                mtdm_pkg::CFG_BATT_CAP:   cap_reg        <= cfg_data[15:0];
                default:                  cap_reg        <= cap_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            go_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            avg_reg       <= '0;
            peak_reg      <= '0;
            prev_reg      <= -32'sd1;
            sum_reg       <= '0;
        end
        else
        begin
            if (state_reg == S_OUT && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (is_op)
            begin
                if (!go_reg)
                begin
                    go_reg <= 1'b1;
                end
                else if (md_rsp.done)
                begin
                    go_reg <= 1'b0;
                end
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        v_reg     <= voltage_dv;
                        cur_reg   <= motor_current_ca;
                        rpm_reg   <= electrical_rpm;
                        tach_reg  <= tachometer;
                        tabs_reg  <= tachometer_abs;
                        state_reg <= S_PWR;
                    end
                end
                S_PWR:
                begin
                    if (go_reg && md_rsp.done)
                    begin
                        watts_reg <= watts_sat[34:0];
                        if (watts_sat > $signed(W'(peak_reg)))
                        begin
                            peak_reg <= watts_sat[33:0];
                        end
                        state_reg <= S_AVG;
                    end
                end
                S_AVG:
                begin
                    if (go_reg && md_rsp.done)
                    begin
                        avg_reg <= 36'(sat_s(avg_sum, S35_MIN, S35_MAX));
                        if (span == '0)
                        begin
                            pct_reg   <= '0;
                            state_reg <= S_DEN;
                        end
                        else
                        begin
                            state_reg <= S_PCT_M;
                        end
                    end
                end
                S_PCT_M:
                begin
                    if (go_reg && md_rsp.done)
                    begin
                        tmp_reg   <= md_res;
                        state_reg <= S_PCT_D;
                    end
                end
                S_PCT_D:
                begin
                    if (go_reg && md_rsp.done)
                    begin
                        pct_reg   <= pct_clamp[13:0];
                        state_reg <= S_DEN;
                    end
                end
                S_DEN:
                begin
                    if (go_reg && md_rsp.done)
                    begin
                        den_reg   <= md_res[17:0];
                        state_reg <= S_CS;
                    end
                end
                S_CS:
                begin
                    if (go_reg && md_rsp.done)
                    begin
                        tmp_reg   <= md_res;
                        state_reg <= S_SPD_M;
                    end
                end
                S_SPD_M:
                begin
                    if (go_reg && md_rsp.done)
                    begin
                        tmp_reg   <= md_res;
                        state_reg <= S_SPD_D;
                    end
                end
                S_SPD_D:
                begin
                    if (go_reg && md_rsp.done)
                    begin
                        speed_reg <= 29'(sat_s(md_res, S29_MIN, S29_MAX));
                        if (!prev_reg[31])
                        begin
                            sum_reg <= sum_sat[47:0];
                        end
                        prev_reg  <= tach_reg;
                        state_reg <= S_SES_M;
                    end
                end
                S_SES_M:
                begin
                    if (go_reg && md_rsp.done)
                    begin
                        tmp_reg   <= md_res;
                        state_reg <= S_SES_D;
                    end
                end
                S_SES_D:
                begin
                    if (go_reg && md_rsp.done)
                    begin
                        sess_reg  <= 42'(sat_s(md_res, S42_MIN, S42_MAX));
                        state_reg <= S_TOT_M;
                    end
                end
                S_TOT_M:
                begin
                    if (go_reg && md_rsp.done)
                    begin
                        tmp_reg   <= md_res;
                        state_reg <= S_TOT_D;
                    end
                end
                S_TOT_D:
                begin
                    if (go_reg && md_rsp.done)
                    begin
                        total_reg <= 34'(sat_s(md_res, '0, U34_MAX));
                        if (avg_reg > 36'sd1000)
                        begin
                            state_reg <= S_RNG_M1;
                        end
                        else
                        begin
                            range_reg <= '0;
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_RNG_M1:
                begin
                    if (go_reg && md_rsp.done)
                    begin
                        tmp_reg   <= md_res;
                        state_reg <= S_RNG_M2;
                    end
                end
                S_RNG_M2:
                begin
                    if (go_reg && md_rsp.done)
                    begin
                        tmp_reg   <= md_res;
                        state_reg <= S_RNG_D;
                    end
                end
                S_RNG_D:
                begin
                    if (go_reg && md_rsp.done)
                    begin
                        range_reg <= 42'(sat_s(md_res, S42_MIN, S42_MAX));
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        o_watts_reg   <= watts_reg;
                        o_avg_reg     <= avg_reg[34:0];
                        o_peak_reg    <= peak_reg;
                        o_pct_reg     <= pct_reg;
                        o_speed_reg   <= speed_reg;
                        o_sess_reg    <= sess_reg;
                        o_total_reg   <= total_reg;
                        o_range_reg   <= range_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall              = (state_reg != S_IDLE);
    assign out_valid             = out_valid_reg;
    assign watts_mw              = o_watts_reg;
    assign avg_watts_mw          = o_avg_reg;
    assign peak_watts_mw         = o_peak_reg;
    assign battery_percent_centi = o_pct_reg;
    assign speed_milli_kmh       = o_speed_reg;
    assign session_distance_m    = o_sess_reg;
    assign total_distance_m      = o_total_reg;
    assign range_estimate_m      = o_range_reg;

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        md_req.start |-> !md_rsp.busy)
        else $error("operation issued while shared unit busy");

    a_peak_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> peak_reg >= $past(peak_reg))
        else $error("peak power decreased");

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> o_pct_reg <= 14'd10000)
        else $error("battery percent above full scale");

    a_session_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SPD_D && go_reg && md_rsp.done && prev_reg[31])
        |=> sum_reg == $past(sum_reg))
        else $error("session sum moved with negative previous tachometer");

endmodule

>>> design/mtdm_muldiv.sv
// Shared iterative signed multiply and divide unit, one bit per cycle.
module mtdm_muldiv
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  mtdm_pkg::md_req_t                    req,
    input  logic signed [mtdm_pkg::MD_W-1:0]     a,
    input  logic signed [mtdm_pkg::MD_W-1:0]     b,
    output mtdm_pkg::md_rsp_t                    rsp,
    output logic signed [mtdm_pkg::MD_W-1:0]     result
);

    typedef enum logic
    {
        U_IDLE,
        U_RUN
    } ustate_t;

    ustate_t                          state_reg;
    logic [mtdm_pkg::MD_CNT_W-1:0]    cnt_reg;
    mtdm_pkg::md_op_t                 op_reg;
    logic                             neg_reg;
    logic                             done_reg;
    logic [mtdm_pkg::MD_W-1:0]        acc_reg;
    logic [mtdm_pkg::MD_W-1:0]        opa_reg;
    logic [mtdm_pkg::MD_W-1:0]        opb_reg;
    logic [mtdm_pkg::MD_W:0]          rem_reg;
    logic signed [mtdm_pkg::MD_W-1:0] res_reg;

    logic [mtdm_pkg::MD_W-1:0] a_mag;
    logic [mtdm_pkg::MD_W-1:0] b_mag;
    logic [mtdm_pkg::MD_W-1:0] acc_mul;
    logic [mtdm_pkg::MD_W:0]   rem_sh;
    logic                      rem_ge;
    logic [mtdm_pkg::MD_W:0]   rem_next;
    logic [mtdm_pkg::MD_W-1:0] acc_div;
    logic [mtdm_pkg::MD_W-1:0] acc_next;

    always_comb
    begin
        a_mag    = a[mtdm_pkg::MD_W-1] ? (~a + 1'b1) : a;
        b_mag    = b[mtdm_pkg::MD_W-1] ? (~b + 1'b1) : b;
        acc_mul  = acc_reg + (opb_reg[0] ? opa_reg : '0);
        rem_sh   = {rem_reg[mtdm_pkg::MD_W-1:0], acc_reg[mtdm_pkg::MD_W-1]};
        rem_ge   = rem_sh >= {1'b0, opb_reg};
        rem_next = rem_ge ? (rem_sh - {1'b0, opb_reg}) : rem_sh;
        acc_div  = {acc_reg[mtdm_pkg::MD_W-2:0], rem_ge};
        acc_next = (op_reg == mtdm_pkg::MD_MUL) ? acc_mul : acc_div;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            op_reg    <= mtdm_pkg::MD_MUL;
            neg_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                U_IDLE:
                begin
                    if (req.start)
                    begin
                        op_reg  <= req.op;
                        neg_reg <= a[mtdm_pkg::MD_W-1] ^ b[mtdm_pkg::MD_W-1];
                        opb_reg <= b_mag;
                        rem_reg <= '0;
                        cnt_reg <= '1;
                        if (req.op == mtdm_pkg::MD_MUL)
                        begin
                            opa_reg <= a_mag;
                            acc_reg <= '0;
                        end
                        else
                        begin
                            acc_reg <= a_mag;
                        end
                        state_reg <= U_RUN;
                    end
                end
                U_RUN:
                begin
                    acc_reg <= acc_next;
                    rem_reg <= rem_next;
                    opa_reg <= {opa_reg[mtdm_pkg::MD_W-2:0], 1'b0};
                    opb_reg <= (op_reg == mtdm_pkg::MD_MUL) ? {1'b0, opb_reg[mtdm_pkg::MD_W-1:1]}
                                                            : opb_reg;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        res_reg   <= neg_reg ? -$signed(acc_next) : $signed(acc_next);
                        done_reg  <= 1'b1;
                        state_reg <= U_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= U_IDLE;
                end
            endcase
        end
    end

    assign rsp.busy = (state_reg == U_RUN);
    assign rsp.done = done_reg;
    assign result   = res_reg;

endmodule
